### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on a clk_i and an active-low rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define FCCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FCCM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/fccm_pkg.sv
// Types and constants of the FAT16 cluster chain manager.
// No dependencies; used by the controller, the top level and the testbench.
package fccm_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_ALLOC = 2'd2,
    ACT_FREE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ALLOC_SCAN,
    ST_ALLOC_LINK,
    ST_FREE_STEP,
    ST_POST
  } state_e;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } res_t;

  localparam logic [15:0] END_MARK_MIN     = 16'hFFF8;
  localparam logic [15:0] END_MARK         = 16'hFFFF;
  localparam int          FIRST_DATA_ENTRY = 2;
  localparam logic [11:0] CC_RESET         = 12'd4094;

endpackage

### design/fccm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fccm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/fccm_ctrl.sv
// Sequencer of the cluster chain manager: clearing pass, table actions,
// allocation scan and chain walk. Uses fccm_pkg; drives one fccm_ram.
module fccm_ctrl import fccm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  localparam int AW         = $clog2(TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [11:0]   cluster_count_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    action_i,
  input  logic [11:0]   cluster_i,
  input  logic [11:0]   previous_cluster_i,
  input  logic [15:0]   entry_value_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [15:0]   ram_wdata_o,
  output logic [AW-1:0] ram_raddr_o,
  input  logic [15:0]   ram_rdata_i
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] steps_q, steps_d;
  logic [AW-1:0] prev_q, prev_d;
  logic          res_ok_q, res_ok_d;
  logic [15:0]   res_val_q, res_val_d;
  logic          fwd_hit_q, fwd_hit_d;
  logic [15:0]   fwd_data_q;

  logic [15:0]   rd_val;
  logic          cl_in, prev_in, next_in, scan_last;
  logic [AW-1:0] cl_addr;

  // A read issued in the same cycle as a write to that entry sees the new data.
  assign rd_val    = fwd_hit_q ? fwd_data_q : ram_rdata_i;
  assign cl_in     = 32'(cluster_i) < TABLE_DEPTH;
  assign prev_in   = 32'(previous_cluster_i) < TABLE_DEPTH;
  assign next_in   = 32'(rd_val) < TABLE_DEPTH;
  assign cl_addr   = AW'(cluster_i);
  assign scan_last = (32'(addr_q) >= 32'(cluster_count_i) + 32'd1) || (addr_q == LAST_ADDR);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    steps_d     = steps_q;
    prev_d      = prev_q;
    res_ok_d    = res_ok_q;
    res_val_d   = res_val_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = '0;
    ram_raddr_o = addr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_val_d = '0;
          unique case (action_e'(action_i))
            ACT_WRITE: begin
              ram_we_o    = cl_in;
              ram_waddr_o = cl_addr;
              ram_wdata_o = entry_value_i;
              res_ok_d    = cl_in;
              state_d     = ST_POST;
            end
            ACT_READ: begin
              ram_raddr_o = cl_addr;
              res_ok_d    = 1'b0;
              state_d     = cl_in ? ST_READ : ST_POST;
            end
            ACT_ALLOC: begin
              prev_d = AW'(previous_cluster_i);
              if (((previous_cluster_i != '0) && !prev_in) || (cluster_count_i == '0)) begin
                res_ok_d = 1'b0;
                state_d  = ST_POST;
              end else begin
                ram_raddr_o = AW'(FIRST_DATA_ENTRY);
                addr_d      = AW'(FIRST_DATA_ENTRY);
                state_d     = ST_ALLOC_SCAN;
              end
            end
            ACT_FREE: begin
              if (cluster_i == '0) begin
                res_ok_d = 1'b1;
                state_d  = ST_POST;
              end else if (!cl_in) begin
                res_ok_d = 1'b0;
                state_d  = ST_POST;
              end else begin
                ram_raddr_o = cl_addr;
                addr_d      = cl_addr;
                steps_d     = '0;
                state_d     = ST_FREE_STEP;
              end
            end
            default: state_d = ST_POST;
          endcase
        end
      end

      ST_READ: begin
        res_ok_d  = 1'b1;
        res_val_d = rd_val;
        state_d   = ST_POST;
      end

      ST_ALLOC_SCAN: begin
        if (rd_val == '0) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = END_MARK;
          res_ok_d    = 1'b1;
          res_val_d   = 16'(addr_q);
          state_d     = (prev_q != '0) ? ST_ALLOC_LINK : ST_POST;
        end else if (scan_last) begin
          res_ok_d = 1'b0;
          state_d  = ST_POST;
        end else begin
          addr_d      = addr_q + 1'b1;
          ram_raddr_o = addr_q + 1'b1;
        end
      end

      ST_ALLOC_LINK: begin
        // Link after the end mark, so a self link replaces it.
        ram_we_o    = 1'b1;
        ram_waddr_o = prev_q;
        ram_wdata_o = 16'(addr_q);
        state_d     = ST_POST;
      end

      ST_FREE_STEP: begin
        ram_we_o = 1'b1;
        if (rd_val >= END_MARK_MIN) begin
          res_ok_d = 1'b1;
          state_d  = ST_POST;
        end else if (!next_in || (steps_q == LAST_ADDR)) begin
          res_ok_d = 1'b0;
          state_d  = ST_POST;
        end else begin
          addr_d      = AW'(rd_val);
          ram_raddr_o = AW'(rd_val);
          steps_d     = steps_q + 1'b1;
        end
      end

      ST_POST: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign fwd_hit_d = ram_we_o && (ram_waddr_o == ram_raddr_o);
  assign res_o     = '{ok: res_ok_q, value: res_val_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      addr_q    <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q    <= steps_d;
    prev_q     <= prev_d;
    res_ok_q   <= res_ok_d;
    res_val_q  <= res_val_d;
    fwd_data_q <= ram_wdata_o;
  end

endmodule

### design/fat16_cluster_chain_manager_top.sv
// FAT16 cluster chain manager: allocation table in internal RAM.
// Uses fccm_pkg; instantiates fccm_ctrl and fccm_ram.
//
// Input channel (in_valid_i/in_ready_o) carries one action per transfer:
// write entry, read entry, allocate a cluster or free a chain. Output channel
// (out_valid_o/out_ready_i) returns one result per action, in order.
// cluster_count is written through cfg_we_i/cfg_wdata_i; the user must do so only while idle (not enforced).
// After reset a clearing pass zeroes the table, one entry per cycle, from entry 0
// to the last; in_ready_o stays low until it ends.
// One action at a time, paced by the single RAM read port and its registered
// read. A write or a rejected action goes straight to the result; a read
// passes a read state; an allocate scans one entry per step, then writes a
// link if one is asked for; a free zeroes one entry per step. The next
// transfer is taken after the result moves into the output register.
// A result waits in the output register while the receiver stalls; the next
// action is taken meanwhile, and its result holds the controller until the
// output register frees.
module fat16_cluster_chain_manager_top import fccm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [11:0] cluster_i,
  input  logic [11:0] previous_cluster_i,
  input  logic [15:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [15:0] cluster_value_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [11:0]   cluster_count_q;
  logic          res_valid, res_ready;
  res_t          res;
  logic          out_valid_q;
  res_t          out_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= CC_RESET;
    end else if (cfg_we_i) begin
      cluster_count_q <= cfg_wdata_i;
    end
  end

  fccm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cluster_count_i    (cluster_count_q),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .cluster_i          (cluster_i),
    .previous_cluster_i (previous_cluster_i),
    .entry_value_i      (entry_value_i),
    .res_valid_o        (res_valid),
    .res_ready_i        (res_ready),
    .res_o              (res),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata)
  );

  fccm_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: load when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign cluster_value_o = out_q.value;

endmodule

### design/fccm_checker.sv
// Port-level checks of the cluster chain manager, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fccm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        ok_i,
  input logic [15:0] cluster_value_i
);

  `FCCM_ASSERT_RST(a_reset_quiet, !rst_ni |=> !in_ready_i && !out_valid_i, "ports not quiet after reset")
  `FCCM_ASSERT(a_one_at_a_time, in_valid_i && in_ready_i |=> !in_ready_i, "second transfer taken while busy")
  `FCCM_ASSERT(a_fail_zero, out_valid_i && !ok_i |-> cluster_value_i == 16'd0, "failed result carries a value")
  `FCCM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) && $stable(cluster_value_i), "stalled result changed")

endmodule

bind fat16_cluster_chain_manager_top fccm_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_i      (in_ready_o),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .ok_i            (ok_o),
  .cluster_value_i (cluster_value_o)
);

### tb/fat16_cluster_chain_manager_top_tb.sv
// Self-checking testbench for the FAT16 cluster chain manager top level.
// Depends on fccm_pkg and fat16_cluster_chain_manager_top; a scoreboard class
// mirrors the allocation table and checks every result in order.
`timescale 1ns / 100ps

module fat16_cluster_chain_manager_top_tb;
  import fccm_pkg::*;

  localparam int TABLE_DEPTH    = 4096;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 285;
  localparam int LONG_WALK      = 200;

  // Mirror of the allocation table plus the queue of results still owed.
  class fat_scoreboard;
    logic [15:0] fat [TABLE_DEPTH];
    logic [11:0] count;
    res_t        awaited [$];
    res_t        last;
    int          fails;

    function new();
      foreach (fat[i]) fat[i] = '0;
      count = CC_RESET;
      fails = 0;
    endfunction

    function void set_count(logic [11:0] v);
      count = v;
    endfunction

    // Length of the walk a free from start would take, table left untouched.
    function int walk_len(int start);
      logic [15:0] t [TABLE_DEPTH];
      int cur;
      int nxt;
      int steps;
      t = fat;
      cur = start;
      steps = 0;
      if (start == 0 || start >= TABLE_DEPTH) return 0;
      while (steps < TABLE_DEPTH) begin
        nxt = t[cur];
        t[cur] = '0;
        steps++;
        if (nxt >= END_MARK_MIN || nxt >= TABLE_DEPTH) return steps;
        cur = nxt;
      end
      return steps;
    endfunction

    function void note_input(action_e act, logic [11:0] cl, logic [11:0] prev,
                             logic [15:0] val);
      res_t r;
      int   last_idx;
      int   cur;
      int   nxt;
      int   steps;
      bit   done;
      r.ok = 1'b0;
      r.value = '0;
      case (act)
        ACT_WRITE: begin
          if (cl < TABLE_DEPTH) begin
            fat[cl] = val;
            r.ok = 1'b1;
          end
        end
        ACT_READ: begin
          if (cl < TABLE_DEPTH) begin
            r.value = fat[cl];
            r.ok = 1'b1;
          end
        end
        ACT_ALLOC: begin
          if (prev == 0 || prev < TABLE_DEPTH) begin
            last_idx = int'(count) + 1;
            for (int i = FIRST_DATA_ENTRY; i <= last_idx && i < TABLE_DEPTH; i++) begin
              if (fat[i] == 16'd0) begin
                fat[i] = END_MARK;
                // link goes in after the mark, so a self link replaces it
                if (prev != 0) fat[prev] = 16'(i);
                r.ok = 1'b1;
                r.value = 16'(i);
                break;
              end
            end
          end
        end
        default: begin
          if (cl == 0) begin
            r.ok = 1'b1;
          end else if (cl < TABLE_DEPTH) begin
            cur = cl;
            steps = 0;
            done = 1'b0;
            while (!done && steps < TABLE_DEPTH) begin
              nxt = fat[cur];
              fat[cur] = '0;
              steps++;
              if (nxt >= END_MARK_MIN) begin
                r.ok = 1'b1;
                done = 1'b1;
              end else if (nxt >= TABLE_DEPTH) begin
                done = 1'b1;
              end else begin
                cur = nxt;
              end
            end
          end
        end
      endcase
      awaited.push_back(r);
      last = r;
    endfunction

    function void check_result(logic ok, logic [15:0] value);
      res_t e;
      if (awaited.size() == 0) begin
        $error("result with no pending action: ok=%0d cluster_value=%0h", ok, value);
        fails++;
        return;
      end
      e = awaited.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0d, actual %0d", e.ok, ok);
        fails++;
      end
      if (value !== e.value) begin
        $error("cluster_value: expected %0h, actual %0h", e.value, value);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  action_i = '0;
  logic [11:0] cluster_i = '0;
  logic [11:0] previous_cluster_i = '0;
  logic [15:0] entry_value_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        ok_o;
  logic [15:0] cluster_value_o;

  fat_scoreboard fat_sb = new();
  int send_idle = 38;
  int recv_idle = 67;
  int hold_asked = 0;
  int hold_granted = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int long_walks_left = 6;
  int chain_head [$];
  int chain_tail [$];
  int phase_cc [6] = '{16, 4094, 1, 4095, 60, 300};

  always #2 clk_i = ~clk_i;

  fat16_cluster_chain_manager_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .cluster_i         (cluster_i),
    .previous_cluster_i(previous_cluster_i),
    .entry_value_i     (entry_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ok_o              (ok_o),
    .cluster_value_o   (cluster_value_o)
  );

  // Result side: check each transfer, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) fat_sb.check_result(ok_o, cluster_value_o);
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_granted != hold_asked) begin
      hold_granted = hold_asked;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(action_e act, logic [11:0] cl, logic [11:0] prev,
                           logic [15:0] val);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    cluster_i <= cl;
    previous_cluster_i <= prev;
    entry_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    fat_sb.note_input(act, cl, prev, val);
  endtask

  // Drop valid and wait until every owed result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (fat_sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(logic [11:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fat_sb.set_count(v);
  endtask

  // Keep frees short except for a small budget of long or runaway walks.
  function bit walk_ok(logic [11:0] cl);
    if (fat_sb.walk_len(cl) <= LONG_WALK) return 1'b1;
    if (long_walks_left > 0) begin
      long_walks_left--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function logic [11:0] pick_cluster();
    int bound;
    bound = int'(fat_sb.count) + 3;
    if (bound > TABLE_DEPTH - 1) bound = TABLE_DEPTH - 1;
    if ($urandom_range(1) == 0) return 12'($urandom);
    return 12'($urandom_range(bound, 0));
  endfunction

  function logic [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return END_MARK_MIN + 16'($urandom_range(7));
      2: return {4'd0, pick_cluster()};
      default: return 16'd0;
    endcase
  endfunction

  task automatic random_item();
    int          r;
    int          k;
    logic [11:0] cl;
    r = $urandom_range(99);
    k = -1;
    if (r < 32) begin
      // grow a tracked chain or start a new one
      if (chain_tail.size() > 0 && $urandom_range(2) != 0)
        k = $urandom_range(chain_tail.size() - 1);
      send_item(ACT_ALLOC, 12'($urandom), (k < 0) ? 12'd0 : 12'(chain_tail[k]),
                16'($urandom));
      if (fat_sb.last.ok) begin
        if (k < 0) begin
          chain_head.push_back(fat_sb.last.value);
          chain_tail.push_back(fat_sb.last.value);
        end else begin
          chain_tail[k] = fat_sb.last.value;
        end
      end
    end else if (r < 52 && chain_head.size() > 0) begin
      k = $urandom_range(chain_head.size() - 1);
      cl = 12'(chain_head[k]);
      chain_head.delete(k);
      chain_tail.delete(k);
      if (walk_ok(cl)) send_item(ACT_FREE, cl, 12'($urandom), 16'($urandom));
      else send_item(ACT_READ, cl, 12'($urandom), 16'($urandom));
    end else if (r < 70) begin
      send_item(ACT_READ, pick_cluster(), 12'($urandom), 16'($urandom));
    end else if (r < 88) begin
      send_item(ACT_WRITE, pick_cluster(), 12'($urandom), pick_value());
    end else if (r < 94) begin
      send_item(ACT_ALLOC, 12'($urandom), 12'($urandom), 16'($urandom));
    end else begin
      cl = pick_cluster();
      if (walk_ok(cl)) send_item(ACT_FREE, cl, 12'($urandom), 16'($urandom));
      else send_item(ACT_READ, cl, 12'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, default cluster_count
    send_item(ACT_READ, 12'd4095, 12'd0, 16'd0);
    send_item(ACT_WRITE, 12'd4095, 12'd4095, 16'hFFFF);
    send_item(ACT_READ, 12'd4095, 12'd0, 16'd0);
    send_item(ACT_WRITE, 12'd0, 12'd0, 16'd0);
    send_item(ACT_ALLOC, 12'd0, 12'd0, 16'd0);
    send_item(ACT_ALLOC, 12'd4095, 12'd2, 16'hFFFF);
    send_item(ACT_ALLOC, 12'd0, 12'd4095, 16'd0);
    send_item(ACT_READ, 12'd2, 12'd0, 16'd0);
    send_item(ACT_FREE, 12'd2, 12'd0, 16'd0);
    // self link: the new cluster is its own previous cluster
    send_item(ACT_ALLOC, 12'd0, 12'd2, 16'd0);
    send_item(ACT_READ, 12'd2, 12'd0, 16'd0);
    send_item(ACT_FREE, 12'd0, 12'd4095, 16'hFFFF);
    // chain leaves the table, also just below the end-mark range
    send_item(ACT_WRITE, 12'd10, 12'd0, 16'h1000);
    send_item(ACT_FREE, 12'd10, 12'd0, 16'd0);
    send_item(ACT_WRITE, 12'd12, 12'd0, 16'hFFF7);
    send_item(ACT_FREE, 12'd12, 12'd0, 16'd0);
    // zero inside a chain is followed to entry 0
    send_item(ACT_WRITE, 12'd0, 12'd0, 16'hFFF8);
    send_item(ACT_WRITE, 12'd9, 12'd0, 16'd0);
    send_item(ACT_FREE, 12'd9, 12'd0, 16'd0);
    // runaway chain: ends up circling on entry 0
    send_item(ACT_WRITE, 12'd7, 12'd0, 16'd7);
    send_item(ACT_FREE, 12'd7, 12'd0, 16'd0);
    write_count(12'd3);
    send_item(ACT_ALLOC, 12'd0, 12'd0, 16'd0);
    send_item(ACT_ALLOC, 12'd0, 12'd0, 16'd0);
    write_count(12'd0);
    send_item(ACT_ALLOC, 12'd0, 12'd0, 16'd0);

    for (int p = 0; p < 6; p++) begin
      write_count(12'(phase_cc[p]));
      send_idle = (p < 2) ? 38 : (p < 4) ? 67 : 0;
      recv_idle = (p < 2) ? 67 : (p < 4) ? 38 : 0;
      if (p == 4) hold_asked++;
      repeat (PHASE_ITEMS) random_item();
    end

    // widest scan range, then back to the default one
    write_count(12'd4095);
    send_item(ACT_ALLOC, 12'($urandom), 12'd0, 16'($urandom));
    write_count(12'd4094);
    send_item(ACT_ALLOC, 12'($urandom), 12'd0, 16'($urandom));
    send_item(ACT_READ, 12'd4095, 12'($urandom), 16'($urandom));

    drain();
    if (fat_sb.fails == 0 && fat_sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/fccm_pkg.sv
design/fccm_ram.sv
design/fccm_ctrl.sv
design/fat16_cluster_chain_manager_top.sv
design/fccm_checker.sv
tb/fat16_cluster_chain_manager_top_tb.sv
